// ----- hdl/altok_pkg.sv -----
// Shared types and constants for the assembler line tokenizer.
`default_nettype none

package altok_pkg;

    // Character codes that the line grammar treats specially
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_DIG_0  = 8'h30;
    localparam logic [7:0] CH_DIG_9  = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;

    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 16;

    typedef enum logic [3:0] {
        PH_START      = 4'd0,
        PH_AFTER_EQ   = 4'd1,
        PH_LABEL      = 4'd2,
        PH_AFTER_COL  = 4'd3,
        PH_LABEL_TAIL = 4'd4,
        PH_SEP_OP     = 4'd5,
        PH_OPERATION  = 4'd6,
        PH_SEP_OPND   = 4'd7,
        PH_OPERANDS   = 4'd8,
        PH_SEP_END    = 4'd9,
        PH_TAIL       = 4'd10,
        PH_COMMENT    = 4'd11,
        PH_ERROR      = 4'd12
    } phase_t;

    typedef enum logic [2:0] {
        ROLE_NONE  = 3'd0,
        ROLE_PUNCT = 3'd1,
        ROLE_LABEL = 3'd2,
        ROLE_OP    = 3'd3,
        ROLE_OPND  = 3'd4,
        ROLE_TEXT  = 3'd5
    } role_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_LABEL = 2'd2,
        ERR_TOKEN = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        ST_ENTRY     = 2'd0,
        ST_BLANK     = 2'd1,
        ST_BAD_LABEL = 2'd2,
        ST_BAD_TOKEN = 2'd3
    } status_t;

    // Character class flags from the classifier
    typedef struct packed {
        logic ws;
        logic sep;
        logic lstart;
        logic lcont;
        logic star;
        logic equal;
        logic colon;
    } char_class_t;

    // Per-line parser state
    typedef struct packed {
        phase_t phase;
        logic   seen_nonblank;
        logic   label_flag;
        logic   global_flag;
        logic   operation_flag;
        logic   operands_flag;
        logic   comment_flag;
        err_t   err;
    } parse_state_t;

    // One result word
    typedef struct packed {
        role_t   role;
        logic    line_done;
        status_t status;
        logic    has_label;
        logic    label_global;
        logic    has_operation;
        logic    has_operands;
        logic    has_comment;
    } result_t;

    localparam parse_state_t STATE_CLEAR = '{
        phase: PH_START, seen_nonblank: 1'b0, label_flag: 1'b0, global_flag: 1'b0,
        operation_flag: 1'b0, operands_flag: 1'b0, comment_flag: 1'b0, err: ERR_NONE
    };

endpackage

`default_nettype wire

// ----- hdl/assembler_line_tokenizer.sv -----
// Top level of the assembler line tokenizer: input register, parser step, result register.
//
// Usage: feed source bytes on the s_ channel, one byte per word in s_tdata[7:0].
// A word with s_tlast high ends the current line; its s_tdata is ignored.
// Every accepted word produces exactly one result word on the m_ channel.
// A byte word yields its role in m_tdata[2:0] with m_tlast low. A line-end
// word yields m_tlast high with the line status and presence flags, and
// returns the parser to the start of a new line.
// Path: an accepted word waits in the input register, passes the parser step and
// is registered in the result register, which drives m_tvalid.
// Throughput: one word per cycle while m_tready is high, set by the combinational
// parser step between the input register and the result register.
// Stall: while m_tready is low the result holds, and the input register still
// takes one more word; s_tready drops only once both registers are full.
// Reset: aresetn low clears both registers and puts the parser at line start
// with all flags clear.
`default_nettype none

module assembler_line_tokenizer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata: char_code[7:0]
    input  wire logic [7:0]  s_tdata,
    input  wire logic        s_tlast,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // m_tdata: char_role[2:0], line_status[4:3], has_label[5], label_global[6],
    //          has_operation[7], has_operands[8], has_comment[9], zero[15:10]
    output logic [15:0]      m_tdata,
    output logic             m_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready
);
    import altok_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   in_char_reg;
    logic         in_last_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    logic         out_valid_reg;
    result_t      out_res_reg;
    result_t      res_next;
    char_class_t  cls;
    logic         advance;

    // Move a word into the result register when it is empty or being taken
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    altok_char_class u_class (
        .char_code (in_char_reg),
        .cls       (cls)
    );

    altok_step u_step (
        .st       (state_reg),
        .cls      (cls),
        .line_end (in_last_reg),
        .st_next  (state_next),
        .res      (res_next)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Parser state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= STATE_CLEAR;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                state_reg <= state_next;
            end
        end
        if (advance && in_valid_reg) begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_res_reg.line_done;
    assign m_tdata  = {6'd0, out_res_reg.has_comment, out_res_reg.has_operands,
                       out_res_reg.has_operation, out_res_reg.label_global,
                       out_res_reg.has_label, out_res_reg.status, out_res_reg.role};

endmodule

`default_nettype wire

// ----- hdl/altok_char_class.sv -----
// Character classifier: whitespace, separator, label, star, equal and colon character sets.
`default_nettype none

module altok_char_class (
    input  wire logic [7:0]          char_code,
    output altok_pkg::char_class_t   cls
);
    import altok_pkg::*;

    logic is_alpha;
    logic is_digit;

    // Decode the byte against the grammar's character sets
    always_comb begin
        is_alpha   = (char_code >= CH_UP_A && char_code <= CH_UP_Z) ||
                     (char_code >= CH_LO_A && char_code <= CH_LO_Z);
        is_digit   = (char_code >= CH_DIG_0 && char_code <= CH_DIG_9);
        cls.ws     = (char_code == CH_SPACE) || (char_code >= CH_TAB && char_code <= CH_CR);
        cls.sep    = (char_code == CH_SPACE) || (char_code == CH_TAB);
        cls.lstart = is_alpha || (char_code == CH_AT) || (char_code == CH_UNDER);
        cls.lcont  = cls.lstart || is_digit || (char_code == CH_DOLLAR) ||
                     (char_code == CH_DOT);
        cls.star   = (char_code == CH_STAR);
        cls.equal  = (char_code == CH_EQUAL);
        cls.colon  = (char_code == CH_COLON);
    end

endmodule

`default_nettype wire

// ----- hdl/altok_step.sv -----
// Parser step: next line state and result word for one character or line end.
`default_nettype none

module altok_step (
    input  wire altok_pkg::parse_state_t st,
    input  wire altok_pkg::char_class_t  cls,
    input  wire logic                    line_end,
    output altok_pkg::parse_state_t      st_next,
    output altok_pkg::result_t           res
);
    import altok_pkg::*;

    // Next state
    always_comb begin
        st_next = st;
        if (line_end) begin
            st_next = STATE_CLEAR;
        end else begin
            if (!cls.ws) begin
                st_next.seen_nonblank = 1'b1;
            end
            unique case (st.phase)
                PH_START: begin
                    if (cls.star) begin
                        st_next.comment_flag = 1'b1;
                        st_next.phase        = PH_COMMENT;
                    end else if (cls.equal) begin
                        st_next.phase = PH_AFTER_EQ;
                    end else if (cls.lstart) begin
                        st_next.label_flag = 1'b1;
                        st_next.phase      = PH_LABEL;
                    end else if (cls.sep) begin
                        st_next.phase = PH_SEP_OP;
                    end else if (cls.ws) begin
                        st_next.phase = PH_LABEL_TAIL;
                    end else begin
                        st_next.phase = PH_ERROR;
                        st_next.err   = ERR_LABEL;
                    end
                end
                PH_AFTER_EQ: begin
                    if (cls.lstart) begin
                        st_next.label_flag = 1'b1;
                        st_next.phase      = PH_LABEL;
                    end else begin
                        st_next.phase = PH_ERROR;
                        st_next.err   = ERR_LABEL;
                    end
                end
                PH_LABEL, PH_AFTER_COL: begin
                    if (st.phase == PH_LABEL && cls.lcont) begin
                        st_next.phase = PH_LABEL;
                    end else if (st.phase == PH_LABEL && cls.colon) begin
                        st_next.global_flag = 1'b1;
                        st_next.phase       = PH_AFTER_COL;
                    end else if (cls.sep) begin
                        st_next.phase = PH_SEP_OP;
                    end else if (cls.ws) begin
                        st_next.phase = PH_LABEL_TAIL;
                    end else begin
                        st_next.phase = PH_ERROR;
                        st_next.err   = ERR_LABEL;
                    end
                end
                PH_LABEL_TAIL: begin
                    if (!cls.ws) begin
                        st_next.phase = PH_ERROR;
                        st_next.err   = ERR_LABEL;
                    end
                end
                PH_SEP_OP, PH_SEP_OPND: begin
                    if (cls.sep) begin
                        st_next.phase = st.phase;
                    end else if (cls.ws) begin
                        st_next.phase = PH_TAIL;
                    end else if (cls.star) begin
                        st_next.comment_flag = 1'b1;
                        st_next.phase        = PH_COMMENT;
                    end else if (st.phase == PH_SEP_OP) begin
                        st_next.operation_flag = 1'b1;
                        st_next.phase          = PH_OPERATION;
                    end else begin
                        st_next.operands_flag = 1'b1;
                        st_next.phase         = PH_OPERANDS;
                    end
                end
                PH_OPERATION, PH_OPERANDS: begin
                    if (cls.sep) begin
                        st_next.phase = (st.phase == PH_OPERATION) ? PH_SEP_OPND : PH_SEP_END;
                    end else if (cls.ws) begin
                        st_next.phase = PH_TAIL;
                    end
                end
                PH_SEP_END: begin
                    if (cls.sep) begin
                        st_next.phase = PH_SEP_END;
                    end else if (cls.ws) begin
                        st_next.phase = PH_TAIL;
                    end else if (cls.star) begin
                        st_next.comment_flag = 1'b1;
                        st_next.phase        = PH_COMMENT;
                    end else begin
                        st_next.phase = PH_ERROR;
                        st_next.err   = ERR_TOKEN;
                    end
                end
                PH_TAIL: begin
                    if (!cls.ws) begin
                        st_next.phase = PH_ERROR;
                        st_next.err   = ERR_TOKEN;
                    end
                end
                PH_COMMENT: begin
                    st_next.phase = PH_COMMENT;
                end
                default: begin
                    st_next.phase = PH_ERROR;
                end
            endcase
        end
    end

    // Result word
    always_comb begin
        res = '{role: ROLE_NONE, line_done: 1'b0, status: ST_ENTRY, has_label: 1'b0,
                label_global: 1'b0, has_operation: 1'b0, has_operands: 1'b0,
                has_comment: 1'b0};
        if (line_end) begin
            res.line_done     = 1'b1;
            res.has_label     = st.label_flag;
            res.label_global  = st.global_flag;
            res.has_operation = st.operation_flag;
            res.has_operands  = st.operands_flag;
            res.has_comment   = st.comment_flag;
            if (!st.seen_nonblank) begin
                res.status = ST_BLANK;
            end else if (st.err == ERR_LABEL) begin
                res.status = ST_BAD_LABEL;
            end else if (st.err == ERR_TOKEN) begin
                res.status = ST_BAD_TOKEN;
            end else if (st.phase == PH_AFTER_EQ) begin
                res.status = ST_BAD_LABEL;
            end else begin
                res.status = ST_ENTRY;
            end
        end else begin
            unique case (st.phase)
                PH_START: begin
                    if (cls.star || cls.equal) begin
                        res.role = ROLE_PUNCT;
                    end else if (cls.lstart) begin
                        res.role = ROLE_LABEL;
                    end
                end
                PH_AFTER_EQ: begin
                    if (cls.lstart) begin
                        res.role = ROLE_LABEL;
                    end
                end
                PH_LABEL: begin
                    if (cls.lcont) begin
                        res.role = ROLE_LABEL;
                    end else if (cls.colon) begin
                        res.role = ROLE_PUNCT;
                    end
                end
                PH_SEP_OP, PH_SEP_OPND: begin
                    if (!cls.ws) begin
                        if (cls.star) begin
                            res.role = ROLE_PUNCT;
                        end else if (st.phase == PH_SEP_OP) begin
                            res.role = ROLE_OP;
                        end else begin
                            res.role = ROLE_OPND;
                        end
                    end
                end
                PH_OPERATION: begin
                    if (!cls.ws) begin
                        res.role = ROLE_OP;
                    end
                end
                PH_OPERANDS: begin
                    if (!cls.ws) begin
                        res.role = ROLE_OPND;
                    end
                end
                PH_SEP_END: begin
                    if (cls.star) begin
                        res.role = ROLE_PUNCT;
                    end
                end
                PH_COMMENT: begin
                    res.role = ROLE_TEXT;
                end
                default: begin
                    res.role = ROLE_NONE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hdl/altok_checker.sv -----
// Port checker for the assembler line tokenizer, bound to the top level.
`default_nettype none

module altok_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [15:0] m_tdata,
    input  wire logic        m_tlast,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready
);
    import altok_pkg::*;

    // A byte word carries no line status or flags
    a_byte_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[9:3] == 7'd0))
        else $error("byte word carries line status or flags");

    // A line-end word carries no character role
    a_line_no_role: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[2:0] == ROLE_NONE))
        else $error("line-end word carries a character role");

    // Roles stay within the defined set and padding stays zero
    a_role_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[2:0] <= ROLE_TEXT) && (m_tdata[15:10] == 6'd0)))
        else $error("undefined role or nonzero padding");

    // A blank line reports no presence flags
    a_blank_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast && (m_tdata[4:3] == ST_BLANK)) |-> (m_tdata[9:5] == 5'd0))
        else $error("blank line reports presence flags");

    // A stalled result word holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result word changed");

endmodule

bind assembler_line_tokenizer altok_checker u_altok_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
